// ----- rtl/core/pha_pkg.sv -----
`timescale 1ns / 1ps

package pha_pkg;

  // Field widths of the stream items
  localparam int unsigned CH_BITS      = 4;
  localparam int unsigned SAMPLE_BITS  = 12;
  localparam int unsigned BIN_BITS     = 8;
  localparam int unsigned AMP_BITS     = 18;
  localparam int unsigned COUNT_OUT_BITS = 32;
  localparam int unsigned OP_BITS      = 2;

  // Input tdata layout: channel, sample, bin_index from bit 0 up
  localparam int unsigned IN_CH_LSB     = 0;
  localparam int unsigned IN_SMP_LSB    = IN_CH_LSB + CH_BITS;
  localparam int unsigned IN_BIN_LSB    = IN_SMP_LSB + SAMPLE_BITS;
  localparam int unsigned IN_DATA_BITS  = 24;
  localparam int unsigned OUT_DATA_BITS = 64;

  // Pedestal accumulation
  localparam int unsigned PED_SAMPLES = 20;
  localparam int unsigned POS_BITS    = 5;
  localparam int unsigned SUM_BITS    = 17;

  // Binning: bin = 1 + floor(10 * HIST_BINS * A / 98304), 98304 = 3 * 2^15
  localparam int unsigned OVER_LIMIT   = 98304;
  localparam int unsigned SCALE        = 10;
  localparam int unsigned OVER_MIN_AMP = (OVER_LIMIT + SCALE - 1) / SCALE;
  localparam int unsigned AMP_MUL_BITS = 14;
  localparam int unsigned SCALE_BITS   = 12;
  localparam int unsigned PROD_BITS    = AMP_MUL_BITS + SCALE_BITS;
  localparam int unsigned FRAC_SHIFT   = 15;
  localparam int unsigned QUO_BITS     = PROD_BITS - FRAC_SHIFT;
  localparam int unsigned DIV3_MUL     = 683;
  localparam int unsigned DIV3_SHIFT   = 11;
  localparam int unsigned DIV3_BITS    = 21;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned Q_PTR_BITS  = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_FILL,
    CMD_READ,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic {
    RES_AMPLITUDE = 1'b0,
    RES_READ      = 1'b1
  } res_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    cmd_e                        kind;
    logic [CH_BITS-1:0]          channel;
    logic signed [AMP_BITS-1:0]  amp;
    logic [BIN_BITS-1:0]         bin;
  } cmd_t;

endpackage

// ----- rtl/core/pha_front.sv -----
`timescale 1ns / 1ps

module pha_front #(
  parameter int HIST_BINS = 200
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [pha_pkg::IN_DATA_BITS-1:0]     s_axis_tdata_i,
  input  logic [pha_pkg::OP_BITS-1:0]          s_axis_tuser_i,
  input  logic                                 s_axis_tlast_i,
  input  logic                                 stall_i,
  output logic                                 push_o,
  output pha_pkg::cmd_t                        cmd_o
);

  localparam logic [pha_pkg::SCALE_BITS-1:0] HB10 =
    pha_pkg::SCALE_BITS'(pha_pkg::SCALE * HIST_BINS);
  localparam logic [pha_pkg::SUM_BITS-1:0] OVER_MIN =
    pha_pkg::SUM_BITS'(pha_pkg::OVER_MIN_AMP);

  logic                                accept;
  logic [pha_pkg::CH_BITS-1:0]         in_ch;
  logic [pha_pkg::SAMPLE_BITS-1:0]     in_smp;
  logic [pha_pkg::BIN_BITS-1:0]        in_bin;
  pha_pkg::op_e                        in_op;

  logic [pha_pkg::SUM_BITS-1:0]        sum_q, sum_d;
  logic [pha_pkg::SAMPLE_BITS-1:0]     min_q, min_d;
  logic [pha_pkg::POS_BITS-1:0]        pos_q, pos_d;
  logic [pha_pkg::SUM_BITS-1:0]        sum_nx;
  logic [pha_pkg::SAMPLE_BITS-1:0]     min_nx;

  logic                                s1_valid_d;
  pha_pkg::cmd_e                       s1_kind_d;

  logic                                s1_valid_q, s2_valid_q, s3_valid_q;
  pha_pkg::cmd_e                       s1_kind_q, s2_kind_q, s3_kind_q;
  logic [pha_pkg::CH_BITS-1:0]         s1_ch_q, s2_ch_q, s3_ch_q;
  logic [pha_pkg::BIN_BITS-1:0]        s1_bin_q, s2_bin_q, s3_bin_q;
  logic [pha_pkg::SUM_BITS-1:0]        s1_sum_q;
  logic [pha_pkg::SAMPLE_BITS-1:0]     s1_min_q;
  logic signed [pha_pkg::AMP_BITS-1:0] s2_amp_q, s3_amp_q;
  logic                                s3_neg_q, s3_over_q;
  logic [pha_pkg::QUO_BITS-1:0]        s3_quo_q;

  logic [pha_pkg::SUM_BITS-1:0]        min20;
  logic signed [pha_pkg::AMP_BITS-1:0] amp_d;
  logic [pha_pkg::PROD_BITS-1:0]       prod;
  logic                                neg_d, over_d;
  logic [pha_pkg::DIV3_BITS-1:0]       div3;
  logic [pha_pkg::BIN_BITS-1:0]        fill_bin;

  assign in_ch  = s_axis_tdata_i[pha_pkg::IN_CH_LSB +: pha_pkg::CH_BITS];
  assign in_smp = s_axis_tdata_i[pha_pkg::IN_SMP_LSB +: pha_pkg::SAMPLE_BITS];
  assign in_bin = s_axis_tdata_i[pha_pkg::IN_BIN_LSB +: pha_pkg::BIN_BITS];
  assign in_op  = pha_pkg::op_e'(s_axis_tuser_i);

  assign s_axis_tready_o = !stall_i;
  assign accept          = s_axis_tvalid_i && !stall_i;

  // Pedestal sum covers the first samples only; minimum tracks all of them
  assign sum_nx = (pos_q < pha_pkg::POS_BITS'(pha_pkg::PED_SAMPLES)) ?
                  sum_q + pha_pkg::SUM_BITS'(in_smp) : sum_q;
  assign min_nx = (in_smp < min_q) ? in_smp : min_q;

  always_comb begin
    sum_d      = sum_q;
    min_d      = min_q;
    pos_d      = pos_q;
    s1_valid_d = 1'b0;
    s1_kind_d  = pha_pkg::CMD_FILL;
    if (accept) begin
      unique case (in_op)
        pha_pkg::OP_SAMPLE: begin
          if (s_axis_tlast_i) begin
            sum_d      = '0;
            min_d      = '1;
            pos_d      = '0;
            s1_valid_d = 1'b1;
          end else begin
            sum_d = sum_nx;
            min_d = min_nx;
            if (pos_q < pha_pkg::POS_BITS'(pha_pkg::PED_SAMPLES)) begin
              pos_d = pos_q + 1'b1;
            end
          end
        end
        pha_pkg::OP_READ: begin
          s1_valid_d = 1'b1;
          s1_kind_d  = pha_pkg::CMD_READ;
        end
        pha_pkg::OP_CLEAR: begin
          s1_valid_d = 1'b1;
          s1_kind_d  = pha_pkg::CMD_CLEAR;
        end
        default: begin
          s1_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      min_q <= '1;
      pos_q <= '0;
    end else begin
      sum_q <= sum_d;
      min_q <= min_d;
      pos_q <= pos_d;
    end
  end

  // Stage 2: amplitude = pedestal sum - 20 * minimum
  assign min20 = pha_pkg::SUM_BITS'({s1_min_q, 4'b0000}) +
                 pha_pkg::SUM_BITS'({s1_min_q, 2'b00});
  assign amp_d = $signed({1'b0, s1_sum_q}) - $signed({1'b0, min20});

  // Stage 3: range class and scaled product, then drop the 2^15 factor
  assign neg_d  = s2_amp_q[pha_pkg::AMP_BITS-1];
  assign over_d = !neg_d && (s2_amp_q[pha_pkg::SUM_BITS-1:0] >= OVER_MIN);
  assign prod   = pha_pkg::PROD_BITS'(s2_amp_q[pha_pkg::AMP_MUL_BITS-1:0]) *
                  pha_pkg::PROD_BITS'(HB10);

  // Divide by three with a reciprocal, exact for quotients below 2048
  assign div3     = pha_pkg::DIV3_BITS'(s3_quo_q) *
                    pha_pkg::DIV3_BITS'(pha_pkg::DIV3_MUL);
  assign fill_bin = pha_pkg::BIN_BITS'(div3[pha_pkg::DIV3_BITS-1:pha_pkg::DIV3_SHIFT]) +
                    pha_pkg::BIN_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (!stall_i) begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      s1_kind_q <= s1_kind_d;
      s1_ch_q   <= in_ch;
      s1_bin_q  <= in_bin;
      s1_sum_q  <= sum_nx;
      s1_min_q  <= min_nx;
      s2_kind_q <= s1_kind_q;
      s2_ch_q   <= s1_ch_q;
      s2_bin_q  <= s1_bin_q;
      s2_amp_q  <= amp_d;
      s3_kind_q <= s2_kind_q;
      s3_ch_q   <= s2_ch_q;
      s3_bin_q  <= s2_bin_q;
      s3_amp_q  <= s2_amp_q;
      s3_neg_q  <= neg_d;
      s3_over_q <= over_d;
      s3_quo_q  <= prod[pha_pkg::PROD_BITS-1:pha_pkg::FRAC_SHIFT];
    end
  end

  always_comb begin
    cmd_o.kind    = s3_kind_q;
    cmd_o.channel = s3_ch_q;
    cmd_o.amp     = s3_amp_q;
    cmd_o.bin     = s3_bin_q;
    if (s3_kind_q == pha_pkg::CMD_FILL) begin
      if (s3_neg_q) begin
        cmd_o.bin = '0;
      end else if (s3_over_q) begin
        cmd_o.bin = pha_pkg::BIN_BITS'(HIST_BINS + 1);
      end else begin
        cmd_o.bin = fill_bin;
      end
    end else begin
      cmd_o.amp = '0;
    end
  end

  assign push_o = s3_valid_q && !stall_i;

endmodule

// ----- rtl/core/pha_queue.sv -----
`timescale 1ns / 1ps

module pha_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pha_pkg::cmd_t  push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pha_pkg::cmd_t  head_cmd_o
);

  pha_pkg::cmd_t                   entry_q [pha_pkg::QUEUE_DEPTH];
  logic [pha_pkg::Q_PTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [pha_pkg::Q_PTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [pha_pkg::Q_PTR_BITS:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == (pha_pkg::Q_PTR_BITS + 1)'(pha_pkg::QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign head_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- rtl/core/pha_back.sv -----
`timescale 1ns / 1ps

module pha_back #(
  parameter int CHANNELS   = 16,
  parameter int HIST_BINS  = 200,
  parameter int COUNT_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  pha_pkg::cmd_t                        q_cmd_i,
  output logic                                 q_pop_o,
  output logic                                 clearing_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [pha_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata_o,
  output logic                                 m_axis_tuser_o
);

  localparam int CH_USED   = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int ROW_BITS  = (CH_USED > 1) ? $clog2(CH_USED) : 1;
  localparam int ADDR_BITS = ROW_BITS + pha_pkg::BIN_BITS;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  logic [COUNT_BITS-1:0]               mem_q [MEM_DEPTH];
  logic [COUNT_BITS-1:0]               rd_data_q;

  pha_pkg::back_state_e                state_q, state_d;
  logic [ADDR_BITS-1:0]                clr_ptr_q, clr_ptr_d;
  pha_pkg::cmd_t                       cmd_q;

  logic                                mem_we, mem_re;
  logic [ADDR_BITS-1:0]                mem_waddr, mem_raddr;
  logic [COUNT_BITS-1:0]               mem_wdata;

  logic                                cmd_ch_ok, cmd_bin_ok;
  logic [ADDR_BITS-1:0]                cmd_addr;
  logic [COUNT_BITS-1:0]               cnt_sat;

  logic                                out_load;
  logic [COUNT_BITS-1:0]               out_cnt_d;
  pha_pkg::res_e                       out_kind_q;
  logic [pha_pkg::CH_BITS-1:0]         out_ch_q;
  logic signed [pha_pkg::AMP_BITS-1:0] out_amp_q;
  logic [pha_pkg::BIN_BITS-1:0]        out_bin_q;
  logic [pha_pkg::COUNT_OUT_BITS-1:0]  out_cnt_q;

  assign cmd_ch_ok  = (32'(cmd_q.channel) < 32'(CH_USED));
  assign cmd_bin_ok = ({1'b0, cmd_q.bin} <= 9'(HIST_BINS + 1));
  assign cmd_addr   = {cmd_q.channel[ROW_BITS-1:0], cmd_q.bin};
  assign cnt_sat    = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    clr_ptr_d = clr_ptr_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cmd_addr;
    mem_raddr = {q_cmd_i.channel[ROW_BITS-1:0], q_cmd_i.bin};
    mem_wdata = cnt_sat;
    out_load  = 1'b0;
    out_cnt_d = '0;
    unique case (state_q)
      pha_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_q;
        mem_wdata = '0;
        clr_ptr_d = clr_ptr_q + 1'b1;
        if (clr_ptr_q == '1) begin
          state_d = pha_pkg::ST_IDLE;
        end
      end
      pha_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.kind == pha_pkg::CMD_CLEAR) begin
            clr_ptr_d = '0;
            state_d   = pha_pkg::ST_CLEAR;
          end else begin
            mem_re  = 1'b1;
            state_d = pha_pkg::ST_ACCESS;
          end
        end
      end
      pha_pkg::ST_ACCESS: begin
        out_load = 1'b1;
        if (cmd_ch_ok && cmd_bin_ok) begin
          out_cnt_d = rd_data_q;
        end
        // Read-modify-write of the bin, saturating
        if (cmd_q.kind == pha_pkg::CMD_FILL && cmd_ch_ok) begin
          mem_we    = 1'b1;
          out_cnt_d = cnt_sat;
        end
        state_d = pha_pkg::ST_OUT;
      end
      pha_pkg::ST_OUT: begin
        if (m_axis_tready_i) begin
          state_d = pha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pha_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pha_pkg::ST_CLEAR;
      clr_ptr_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_ptr_q <= clr_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
    if (out_load) begin
      out_kind_q <= (cmd_q.kind == pha_pkg::CMD_READ) ? pha_pkg::RES_READ
                                                      : pha_pkg::RES_AMPLITUDE;
      out_ch_q   <= cmd_q.channel;
      out_amp_q  <= cmd_q.amp;
      out_bin_q  <= cmd_q.bin;
      out_cnt_q  <= pha_pkg::COUNT_OUT_BITS'(out_cnt_d);
    end
  end

  assign clearing_o      = (state_q == pha_pkg::ST_CLEAR);
  assign m_axis_tvalid_o = (state_q == pha_pkg::ST_OUT);
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {2'b00, out_cnt_q, out_bin_q, out_amp_q, out_ch_q};

  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pha_pkg::ST_ACCESS && mem_we) |-> (mem_wdata != '0))
    else $error("fill wrote a zero count");

  a_access_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pha_pkg::ST_ACCESS) |=> m_axis_tvalid_o)
    else $error("memory access not followed by a result");

  a_bad_channel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pha_pkg::ST_ACCESS && !cmd_ch_ok) |=> (out_cnt_q == '0))
    else $error("result for an absent channel carries a count");

endmodule

// ----- rtl/core/pulse_height_histogrammer.sv -----
`timescale 1ns / 1ps

// Pulse height histogrammer. Samples of negative-going pulses enter one per
// cycle unless stalled; a waveform's first 20 samples form the pedestal sum,
// the lowest sample the peak, and the tlast-flagged sample closes it with an
// amplitude result (pedestal sum - 20 * minimum) that is also counted into the
// channel's histogram (bin 0 underflow, 1..HIST_BINS over 0 to 0.3 V, then
// overflow). A read returns one bin count, a clear zeroes every histogram.
// The front end takes one item per cycle while the queue is not full and no
// clear runs, and passes it through the registered stages s1, s2 and s3 into
// the command queue; each result then goes through the histogram states in
// order (pop with memory read, bin update, output held until m_axis_tready),
// and no new command is taken until that output is accepted. After reset and
// after each clear the store of 256 * 2^max(1, ceil(log2(min(CHANNELS,16))))
// entries (4096 for 16 channels) is swept one entry a cycle; no item is accepted.
module pulse_height_histogrammer #(
  parameter int CHANNELS   = 16,
  parameter int HIST_BINS  = 200,
  parameter int COUNT_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // channel[3:0], sample[15:4], bin_index[23:16]
  input  logic [pha_pkg::IN_DATA_BITS-1:0]   s_axis_tdata_i,
  // operation[1:0]
  input  logic [pha_pkg::OP_BITS-1:0]        s_axis_tuser_i,
  // last_sample
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // result_channel[3:0], amplitude_x20[21:4], amplitude_bin[29:22],
  // bin_count[61:30], zero fill[63:62]
  output logic [pha_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata_o,
  // result_kind
  output logic                               m_axis_tuser_o
);

  logic           q_full, q_valid, q_pop, q_push, clearing;
  pha_pkg::cmd_t  push_cmd, head_cmd;

  pha_front #(
    .HIST_BINS (HIST_BINS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .stall_i         (q_full || clearing),
    .push_o          (q_push),
    .cmd_o           (push_cmd)
  );

  pha_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_cmd_o (head_cmd)
  );

  pha_back #(
    .CHANNELS   (CHANNELS),
    .HIST_BINS  (HIST_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (head_cmd),
    .q_pop_o         (q_pop),
    .clearing_o      (clearing),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pha_pkg::*;

  localparam int unsigned CHANNELS     = 16;
  localparam int unsigned HIST_BINS    = 200;
  localparam int unsigned ROW_SIZE     = 256;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    res_e                      kind;
    logic [CH_BITS-1:0]        channel;
    logic [AMP_BITS-1:0]       amp;
    logic [BIN_BITS-1:0]       bin;
    logic [COUNT_OUT_BITS-1:0] count;
  } result_t;

  // Tracks the pedestal accumulator and every histogram, and holds the
  // results still owed by the block in arrival order.
  class histogram_tracker;
    int unsigned              hist [CHANNELS][ROW_SIZE];
    logic [SUM_BITS-1:0]      ped_sum;
    logic [SAMPLE_BITS-1:0]   run_min;
    int unsigned              ped_count;
    logic [BIN_BITS-1:0]      last_bin [CHANNELS];
    result_t                  pending [$];
    int unsigned              errors;
    int unsigned              fills;
    int unsigned              reads;
    int unsigned              clears;

    function new();
      clear_store();
      restart_waveform();
      foreach (last_bin[c]) last_bin[c] = '0;
      errors = 0;
      fills  = 0;
      reads  = 0;
      clears = 0;
    endfunction

    function void clear_store();
      foreach (hist[c, b]) hist[c][b] = 0;
    endfunction

    function void restart_waveform();
      ped_sum   = '0;
      run_min   = '1;
      ped_count = 0;
    endfunction

    function void add_pending(result_t r);
      pending.insert(pending.size(), r);
    endfunction

    function void note_item(logic [OP_BITS-1:0] op, logic [CH_BITS-1:0] ch,
                            logic [SAMPLE_BITS-1:0] smp, logic last,
                            logic [BIN_BITS-1:0] bidx);
      result_t     r;
      int          amp;
      int unsigned b;
      case (op)
        OP_SAMPLE: begin
          if (ped_count < PED_SAMPLES) begin
            ped_sum += smp;
            ped_count++;
          end
          if (smp < run_min) run_min = smp;
          if (last) begin
            amp = int'(ped_sum) - int'(PED_SAMPLES) * int'(run_min);
            if (amp < 0) b = 0;
            else if (longint'(amp) * SCALE >= OVER_LIMIT) b = HIST_BINS + 1;
            else b = 1 + int'((longint'(amp) * SCALE * HIST_BINS) / OVER_LIMIT);
            // count saturates at all ones
            if (hist[ch][b] != 32'hFFFF_FFFF) hist[ch][b]++;
            r.kind    = RES_AMPLITUDE;
            r.channel = ch;
            r.amp     = amp[AMP_BITS-1:0];
            r.bin     = b[BIN_BITS-1:0];
            r.count   = hist[ch][b];
            add_pending(r);
            last_bin[ch] = b[BIN_BITS-1:0];
            fills++;
            restart_waveform();
          end
        end
        OP_READ: begin
          r.kind    = RES_READ;
          r.channel = ch;
          r.amp     = '0;
          r.bin     = bidx;
          r.count   = (bidx <= HIST_BINS + 1) ? hist[ch][bidx] : 0;
          add_pending(r);
          reads++;
        end
        OP_CLEAR: begin
          clear_store();
          clears++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic kind, logic [CH_BITS-1:0] ch,
                               logic [AMP_BITS-1:0] amp, logic [BIN_BITS-1:0] bin,
                               logic [COUNT_OUT_BITS-1:0] cnt);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat: kind %0d channel %0d", kind, ch);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind) begin
        $error("result_kind: expected %0d, actual %0d", e.kind, kind);
        errors++;
      end
      if (ch !== e.channel) begin
        $error("result_channel: expected %0d, actual %0d", e.channel, ch);
        errors++;
      end
      if (amp !== e.amp) begin
        $error("amplitude_x20: expected %0d, actual %0d", $signed(e.amp), $signed(amp));
        errors++;
      end
      if (bin !== e.bin) begin
        $error("amplitude_bin: expected %0d, actual %0d", e.bin, bin);
        errors++;
      end
      if (cnt !== e.count) begin
        $error("bin_count: expected %0d, actual %0d", e.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
  logic [OP_BITS-1:0]        s_axis_tuser = '0;
  logic                      s_axis_tlast = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
  logic                      m_axis_tuser;

  logic                      hold_off = 1'b0;
  logic                      pressure_go = 1'b0;
  int unsigned               send_idle_pct = 0;
  int unsigned               recv_idle_pct = 0;
  int unsigned               beats_sent = 0;

  histogram_tracker tracker = new();

  always #5 clk_i = ~clk_i;

  pulse_height_histogrammer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  // Check each result beat, then pick the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_result(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[21:4],
                           m_axis_tdata[29:22], m_axis_tdata[61:30]);
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver stall so the result path backs up into the input.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("pulse_height_histogrammer test failed");
    $finish;
  end

  task automatic send_item(logic [OP_BITS-1:0] op, logic [CH_BITS-1:0] ch,
                           logic [SAMPLE_BITS-1:0] smp, logic last,
                           logic [BIN_BITS-1:0] bidx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bidx, smp, ch};
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_item(op, ch, smp, last, bidx);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  task automatic send_read();
    logic [CH_BITS-1:0]  ch;
    logic [BIN_BITS-1:0] bin;
    ch  = CH_BITS'($urandom_range(CHANNELS - 1));
    bin = ($urandom_range(99) < 60) ? tracker.last_bin[ch] : BIN_BITS'($urandom_range(255));
    send_item(OP_READ, ch, SAMPLE_BITS'($urandom), 1'($urandom), bin);
  endtask

  // A flat baseline with a little noise and one negative peak; sometimes
  // shorter than the pedestal window, sometimes with other traffic mixed in.
  task automatic send_waveform(logic [CH_BITS-1:0] ch);
    int unsigned        len;
    int unsigned        base;
    int unsigned        depth;
    int unsigned        peak_at;
    int unsigned        pick;
    int                 v;
    logic [CH_BITS-1:0] item_ch;
    len     = ($urandom_range(99) < 30) ? $urandom_range(1, 19) : $urandom_range(20, 28);
    base    = $urandom_range(200, 4095);
    depth   = ($urandom_range(99) < 85) ? $urandom_range(0, 550) : $urandom_range(0, base);
    peak_at = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) send_read();
      else if (pick == 4)
        send_item(OP_CLEAR, CH_BITS'($urandom), SAMPLE_BITS'($urandom), 1'($urandom),
                  BIN_BITS'($urandom));
      v = int'(base) + int'($urandom_range(6)) - 3;
      if (i == peak_at) v = int'(base) - int'(depth);
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      item_ch = (i + 1 < len && $urandom_range(99) < 20) ? CH_BITS'($urandom) : ch;
      send_item(OP_SAMPLE, item_ch, v[SAMPLE_BITS-1:0], i + 1 == len,
                BIN_BITS'($urandom));
    end
  endtask

  task automatic run_phase(int unsigned items, int unsigned send_pct,
                           int unsigned recv_pct);
    int unsigned target;
    int unsigned result_target;
    int unsigned pick;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    target        = beats_sent + items;
    result_target = tracker.fills + tracker.reads + 10;
    while (beats_sent < target || tracker.fills + tracker.reads < result_target) begin
      pick = $urandom_range(99);
      if (pick < 60) send_waveform(CH_BITS'($urandom));
      else if (pick < 92) send_read();
      else if (pick < 95)
        send_item(OP_CLEAR, CH_BITS'($urandom), SAMPLE_BITS'($urandom), 1'($urandom),
                  BIN_BITS'($urandom));
      else
        send_item(OP_BITS'($urandom), CH_BITS'($urandom), SAMPLE_BITS'($urandom),
                  1'($urandom), BIN_BITS'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty store, including the overflow bin and an index past it
    send_item(OP_READ, 4'd0, 12'd0, 1'b0, 8'd0);
    send_item(OP_READ, 4'd15, 12'hFFF, 1'b1, 8'(HIST_BINS + 1));
    send_item(OP_READ, 4'd3, 12'd0, 1'b0, 8'hFF);
    // one-sample waveforms: zero amplitude, deep underflow
    send_item(OP_SAMPLE, 4'd0, 12'd0, 1'b1, 8'd0);
    send_item(OP_SAMPLE, 4'd15, 12'hFFF, 1'b1, 8'hFF);
    send_item(OP_UNUSED, 4'd2, 12'h800, 1'b1, 8'd1);
    // top regular bin and first overflow, channels interleaved
    send_item(OP_SAMPLE, 4'd6, 12'd4095, 1'b0, 8'd0);
    send_item(OP_SAMPLE, 4'd12, 12'd4095, 1'b0, 8'd0);
    send_item(OP_SAMPLE, 4'd1, 12'd1640, 1'b0, 8'd0);
    send_item(OP_SAMPLE, 4'd9, 12'd0, 1'b1, 8'd0);
    send_item(OP_SAMPLE, 4'd9, 12'd4095, 1'b0, 8'd0);
    send_item(OP_SAMPLE, 4'd9, 12'd4095, 1'b0, 8'd0);
    send_item(OP_SAMPLE, 4'd9, 12'd1641, 1'b0, 8'd0);
    send_item(OP_SAMPLE, 4'd9, 12'd0, 1'b1, 8'd0);
    send_item(OP_READ, 4'd0, 12'd0, 1'b0, 8'd1);
    send_item(OP_READ, 4'd9, 12'd0, 1'b0, 8'(HIST_BINS + 1));
    // clear in the middle of a waveform leaves the accumulator alone
    send_item(OP_SAMPLE, 4'd4, 12'd2000, 1'b0, 8'd0);
    send_item(OP_CLEAR, 4'd0, 12'd0, 1'b0, 8'd0);
    send_item(OP_SAMPLE, 4'd4, 12'd1600, 1'b1, 8'd0);
    send_item(OP_READ, 4'd0, 12'd0, 1'b0, 8'd1);
    send_item(OP_READ, 4'd4, 12'd0, 1'b0, 8'd0);

    run_phase(160, 10, 85);
    run_phase(160, 85, 10);
    pressure_go <= 1'b1;
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    repeat (12)
      send_item(OP_SAMPLE, CH_BITS'($urandom), SAMPLE_BITS'($urandom), 1'b1,
                BIN_BITS'($urandom));
    run_phase(150, 0, 0);

    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d input beats: %0d waveforms closed, %0d bin reads, %0d clears,",
             beats_sent, tracker.fills, tracker.reads, tracker.clears);
    $display("under sender and receiver idling and one long receiver stall.");
    if (tracker.errors == 0)
      $display("pulse_height_histogrammer test passed");
    else
      $display("pulse_height_histogrammer test failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/pha_pkg.sv
rtl/core/pha_front.sv
rtl/core/pha_queue.sv
rtl/core/pha_back.sv
rtl/core/pulse_height_histogrammer.sv
tb/sv/testbench.sv
